// ===== src/olm_pkg.sv =====
// Package for the ordered list with id map: codes, field widths and defaults.
// Used by the channel interfaces and by the top level.
package olm_pkg;

    // Field widths of the channels
    localparam int MODE_W    = 3;
    localparam int POS_W     = 8;
    localparam int HANDLE_W  = 32;
    localparam int LID_W     = 10;
    localparam int STATUS_W  = 2;
    localparam int EID_W     = 10;
    localparam int RIDX_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Default sizing
    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int ID_SPACE_MULT_DEF = 4;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_END  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSUME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM  = 2'd3;

endpackage

// ===== src/olm_if.sv =====
// Channel interfaces of the ordered list: request, response, configuration.
// Depends on olm_pkg for field widths.
interface olm_req_if
    import olm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic [HANDLE_W-1:0] handle;
    logic [LID_W-1:0]    lookup_id;

    modport source (output valid, mode, pos_a, pos_b, handle, lookup_id, input ready);
    modport sink   (input valid, mode, pos_a, pos_b, handle, lookup_id, output ready);
endinterface

interface olm_rsp_if
    import olm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [EID_W-1:0]    entry_id;
    logic [RIDX_W-1:0]   result_index;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, status, entry_id, result_index, count, input ready);
    modport sink   (input valid, status, entry_id, result_index, count, output ready);
endinterface

interface olm_cfg_if
    import olm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ordered_list_with_id_map.sv =====
// Top level of the ordered list with id map: sequencer and its three memories.
// Depends on olm_pkg and the channel interfaces in olm_if.sv.

// One request is taken at a time and answered by one response. After reset a
// clearing pass over all MAX_ENTRIES*ID_SPACE_MULT ids (1024 by default) marks
// every id free; no request is taken meanwhile, configuration writes are.
// Next order and requests found bad at dispatch go straight to the response
// register; lookup reads the id map, swap reads both entries and writes them
// back, append probes ids from the cursor and steps over each id in use. Delete
// finds the entry in the play order, compacts the entries and renumbers the
// order; move shifts the entries between a and b and renumbers the order too
// when random mode is on. Each memory has a single read port: every entry is
// read in one cycle and written back in the next.
module ordered_list_with_id_map
    import olm_pkg::*;
#(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int ID_SPACE_MULT = ID_SPACE_MULT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    olm_req_if.sink   req,
    olm_rsp_if.source rsp,
    olm_cfg_if.sink   cfg
);

    localparam int IDS = MAX_ENTRIES * ID_SPACE_MULT;
    localparam int PW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = $clog2(IDS);
    localparam int XW  = (CW > POS_W) ? CW : POS_W;
    localparam int LW  = ((IW > LID_W) ? IW : LID_W) + 1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [IW-1:0]       ident;
    } ent_word_t;

    typedef struct packed {
        logic          used;
        logic [PW-1:0] pos;
    } map_word_t;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP,
        S_AP_RD, S_AP_CK,
        S_DL_RD, S_DL_FREE, S_DL_FR, S_DL_FC, S_DL_ER, S_DL_EW,
        S_OR_RD, S_OR_WR,
        S_MV_RD, S_MV_SV, S_MV_SR, S_MV_SW, S_MV_FIN,
        S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
        S_LK_RD, S_LK_CK,
        S_DONE
    } state_t;

    // Memories
    ent_word_t     ent_mem [MAX_ENTRIES];
    logic [PW-1:0] ord_mem [MAX_ENTRIES];
    map_word_t     map_mem [IDS];

    ent_word_t     ent_rd_reg;
    logic [PW-1:0] ord_rd_reg;
    map_word_t     map_rd_reg;

    logic          ent_we, ord_we, map_we;
    logic [PW-1:0] ent_rd_addr, ent_wr_addr, ord_rd_addr, ord_wr_addr;
    logic [IW-1:0] map_rd_addr, map_wr_addr;
    ent_word_t     ent_wr_data;
    logic [PW-1:0] ord_wr_data;
    map_word_t     map_wr_data;

    // Control and operand registers
    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [XW-1:0]       a_reg, a_next, b_reg, b_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [LW-1:0]       lid_reg, lid_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       cursor_reg, cursor_next;
    logic [IW-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       ord_reg, ord_next;
    logic                mv_pass_reg, mv_pass_next;
    logic [HANDLE_W-1:0] h_reg, h_next;
    logic [IW-1:0]       id_reg, id_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IW-1:0]       eid_reg, eid_next;
    logic [PW-1:0]       ridx_reg, ridx_next;
    logic                rep_reg, rep_next, sgl_reg, sgl_next;
    logic                cns_reg, cns_next, rnd_reg, rnd_next;
    logic                ov_reg, ov_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic [EID_W-1:0]    oeid_reg, oeid_next;
    logic [RIDX_W-1:0]   oridx_reg, oridx_next;
    logic [COUNT_W-1:0]  ocnt_reg, ocnt_next;

    // Helpers
    logic [XW-1:0] count_x, i_x, p_x;
    logic [IW-1:0] cand;
    logic [PW-1:0] a_p, b_p, i_p, p_new;

    assign count_x = XW'(count_reg);
    assign i_x     = XW'(i_reg);
    assign p_x     = XW'(ord_rd_reg);
    assign a_p     = a_reg[PW-1:0];
    assign b_p     = b_reg[PW-1:0];
    assign i_p     = i_reg[PW-1:0];
    assign cand    = (cursor_reg == IW'(IDS - 1)) ? '0 : cursor_reg + 1'b1;

    // Renumber one play-order word for delete or move
    always_comb
    begin
        p_new = ord_rd_reg;
        if (!mv_pass_reg) begin
            if (p_x > a_reg)
                p_new = ord_rd_reg - 1'b1;
        end else begin
            if (p_x > a_reg && p_x <= b_reg)
                p_new = ord_rd_reg - 1'b1;
            else if (p_x < a_reg && p_x >= b_reg)
                p_new = ord_rd_reg + 1'b1;
            else if (p_x == a_reg)
                p_new = b_p;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid        = ov_reg;
    assign rsp.status       = ost_reg;
    assign rsp.entry_id     = oeid_reg;
    assign rsp.result_index = oridx_reg;
    assign rsp.count        = ocnt_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        handle_next  = handle_reg;
        lid_next     = lid_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        clr_next     = clr_reg;
        i_next       = i_reg;
        ord_next     = ord_reg;
        mv_pass_next = mv_pass_reg;
        h_next       = h_reg;
        id_next      = id_reg;
        status_next  = status_reg;
        eid_next     = eid_reg;
        ridx_next    = ridx_reg;
        rep_next     = rep_reg;
        sgl_next     = sgl_reg;
        cns_next     = cns_reg;
        rnd_next     = rnd_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        oeid_next    = oeid_reg;
        oridx_next   = oridx_reg;
        ocnt_next    = ocnt_reg;

        ent_we      = 1'b0;
        ord_we      = 1'b0;
        map_we      = 1'b0;
        ent_rd_addr = '0;
        ent_wr_addr = '0;
        ent_wr_data = '0;
        ord_rd_addr = '0;
        ord_wr_addr = '0;
        ord_wr_data = '0;
        map_rd_addr = '0;
        map_wr_addr = '0;
        map_wr_data = '0;

        // Configuration writes
        if (cfg.valid) begin
            unique case (cfg.index)
                CFG_REPEAT:  rep_next = cfg.data;
                CFG_SINGLE:  sgl_next = cfg.data;
                CFG_CONSUME: cns_next = cfg.data;
                CFG_RANDOM:  rnd_next = cfg.data;
                default:     ;
            endcase
        end

        // Drop the response once transferred
        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                map_we      = 1'b1;
                map_wr_addr = clr_reg;
                if (clr_reg == IW'(IDS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (req.valid) begin
                    mode_next   = req.mode;
                    a_next      = XW'(req.pos_a);
                    b_next      = XW'(req.pos_b);
                    handle_next = req.handle;
                    lid_next    = LW'(req.lookup_id);
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = ST_OK;
                eid_next    = '0;
                ridx_next   = '0;
                state_next  = S_DONE;
                unique case (mode_reg)
                    MODE_APPEND:
                        if (count_reg >= CW'(MAX_ENTRIES))
                            status_next = ST_FULL;
                        else
                            state_next = S_AP_RD;
                    MODE_DELETE:
                        if (a_reg >= count_x)
                            status_next = ST_BAD;
                        else
                            state_next = S_DL_RD;
                    MODE_MOVE, MODE_SWAP:
                        if (a_reg >= count_x || b_reg >= count_x)
                            status_next = ST_BAD;
                        else if (mode_reg == MODE_MOVE)
                            state_next = S_MV_RD;
                        else
                            state_next = S_SW_RA;
                    MODE_NEXT:
                        if (a_reg >= count_x)
                            status_next = ST_BAD;
                        else if (sgl_reg && rep_reg && !cns_reg)
                            ridx_next = a_p;
                        else if (a_reg + 1'b1 < count_x)
                            ridx_next = a_p + 1'b1;
                        else if (rep_reg && (a_reg != '0 || !cns_reg))
                            ridx_next = '0;
                        else
                            status_next = ST_END;
                    MODE_LOOKUP:
                        if (lid_reg >= LW'(IDS))
                            status_next = ST_BAD;
                        else
                            state_next = S_LK_RD;
                    default:
                        status_next = ST_BAD;
                endcase
            end
            // Probe ids from the cursor until a free one turns up
            S_AP_RD:
            begin
                map_rd_addr = cand;
                cursor_next = cand;
                state_next  = S_AP_CK;
            end
            S_AP_CK:
            begin
                if (map_rd_reg.used) begin
                    state_next = S_AP_RD;
                end else begin
                    ent_we      = 1'b1;
                    ent_wr_addr = count_reg[PW-1:0];
                    ent_wr_data = '{handle: handle_reg, ident: cursor_reg};
                    ord_we      = 1'b1;
                    ord_wr_addr = count_reg[PW-1:0];
                    ord_wr_data = count_reg[PW-1:0];
                    map_we      = 1'b1;
                    map_wr_addr = cursor_reg;
                    map_wr_data = '{used: 1'b1, pos: count_reg[PW-1:0]};
                    count_next  = count_reg + 1'b1;
                    eid_next    = cursor_reg;
                    state_next  = S_DONE;
                end
            end
            // Delete: free the id, find the order slot, compact
            S_DL_RD:
            begin
                ent_rd_addr = a_p;
                state_next  = S_DL_FREE;
            end
            S_DL_FREE:
            begin
                map_we      = 1'b1;
                map_wr_addr = ent_rd_reg.ident;
                i_next      = '0;
                state_next  = S_DL_FR;
            end
            S_DL_FR:
            begin
                ord_rd_addr = i_p;
                state_next  = S_DL_FC;
            end
            S_DL_FC:
            begin
                if (ord_rd_reg == a_p || i_reg + 1'b1 >= count_reg) begin
                    ord_next   = (ord_rd_reg == a_p) ? i_reg : count_reg;
                    count_next = count_reg - 1'b1;
                    i_next     = CW'(a_reg);
                    state_next = S_DL_ER;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_DL_FR;
                end
            end
            S_DL_ER:
            begin
                if (i_reg < count_reg) begin
                    ent_rd_addr = PW'(i_reg + 1'b1);
                    state_next  = S_DL_EW;
                end else begin
                    i_next       = '0;
                    mv_pass_next = 1'b0;
                    state_next   = S_OR_RD;
                end
            end
            S_DL_EW:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = i_p;
                ent_wr_data = ent_rd_reg;
                map_we      = 1'b1;
                map_wr_addr = ent_rd_reg.ident;
                map_wr_data = '{used: 1'b1, pos: i_p};
                i_next      = i_reg + 1'b1;
                state_next  = S_DL_ER;
            end
            // Renumber the play order, closing the gap on delete
            S_OR_RD:
            begin
                if (i_reg < count_reg) begin
                    if (!mv_pass_reg && i_reg >= ord_reg)
                        ord_rd_addr = PW'(i_reg + 1'b1);
                    else
                        ord_rd_addr = i_p;
                    state_next = S_OR_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_OR_WR:
            begin
                ord_we      = 1'b1;
                ord_wr_addr = i_p;
                ord_wr_data = p_new;
                i_next      = i_reg + 1'b1;
                state_next  = S_OR_RD;
            end
            // Move: hold the source entry, shift the span, drop it at b
            S_MV_RD:
            begin
                ent_rd_addr = a_p;
                state_next  = S_MV_SV;
            end
            S_MV_SV:
            begin
                h_next     = ent_rd_reg.handle;
                id_next    = ent_rd_reg.ident;
                i_next     = CW'(a_reg);
                state_next = S_MV_SR;
            end
            S_MV_SR:
            begin
                if (i_x < b_reg) begin
                    ent_rd_addr = PW'(i_reg + 1'b1);
                    state_next  = S_MV_SW;
                end else if (i_x > b_reg) begin
                    ent_rd_addr = PW'(i_reg - 1'b1);
                    state_next  = S_MV_SW;
                end else begin
                    state_next = S_MV_FIN;
                end
            end
            S_MV_SW:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = i_p;
                ent_wr_data = ent_rd_reg;
                map_we      = 1'b1;
                map_wr_addr = ent_rd_reg.ident;
                map_wr_data = '{used: 1'b1, pos: i_p};
                i_next      = (i_x < b_reg) ? i_reg + 1'b1 : i_reg - 1'b1;
                state_next  = S_MV_SR;
            end
            S_MV_FIN:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = b_p;
                ent_wr_data = '{handle: h_reg, ident: id_reg};
                map_we      = 1'b1;
                map_wr_addr = id_reg;
                map_wr_data = '{used: 1'b1, pos: b_p};
                if (rnd_reg) begin
                    i_next       = '0;
                    mv_pass_next = 1'b1;
                    state_next   = S_OR_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            // Swap two entries and their map words
            S_SW_RA:
            begin
                ent_rd_addr = a_p;
                state_next  = S_SW_RB;
            end
            S_SW_RB:
            begin
                h_next      = ent_rd_reg.handle;
                id_next     = ent_rd_reg.ident;
                ent_rd_addr = b_p;
                state_next  = S_SW_WA;
            end
            S_SW_WA:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = a_p;
                ent_wr_data = ent_rd_reg;
                map_we      = 1'b1;
                map_wr_addr = ent_rd_reg.ident;
                map_wr_data = '{used: 1'b1, pos: a_p};
                state_next  = S_SW_WB;
            end
            S_SW_WB:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = b_p;
                ent_wr_data = '{handle: h_reg, ident: id_reg};
                map_we      = 1'b1;
                map_wr_addr = id_reg;
                map_wr_data = '{used: 1'b1, pos: b_p};
                state_next  = S_DONE;
            end
            // Lookup
            S_LK_RD:
            begin
                map_rd_addr = lid_reg[IW-1:0];
                state_next  = S_LK_CK;
            end
            S_LK_CK:
            begin
                if (map_rd_reg.used)
                    ridx_next = map_rd_reg.pos;
                else
                    status_next = ST_BAD;
                state_next = S_DONE;
            end
            // Load the response register once it is free
            S_DONE:
            begin
                if (!ov_reg || rsp.ready) begin
                    ov_next    = 1'b1;
                    ost_next   = status_reg;
                    oeid_next  = EID_W'(eid_reg);
                    oridx_next = RIDX_W'(ridx_reg);
                    ocnt_next  = COUNT_W'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_CLR;
            mode_reg    <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            handle_reg  <= '0;
            lid_reg     <= '0;
            count_reg   <= '0;
            cursor_reg  <= IW'(IDS - 1);
            clr_reg     <= '0;
            i_reg       <= '0;
            ord_reg     <= '0;
            mv_pass_reg <= 1'b0;
            h_reg       <= '0;
            id_reg      <= '0;
            status_reg  <= ST_OK;
            eid_reg     <= '0;
            ridx_reg    <= '0;
            rep_reg     <= 1'b0;
            sgl_reg     <= 1'b0;
            cns_reg     <= 1'b0;
            rnd_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            ost_reg     <= ST_OK;
            oeid_reg    <= '0;
            oridx_reg   <= '0;
            ocnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            handle_reg  <= handle_next;
            lid_reg     <= lid_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            clr_reg     <= clr_next;
            i_reg       <= i_next;
            ord_reg     <= ord_next;
            mv_pass_reg <= mv_pass_next;
            h_reg       <= h_next;
            id_reg      <= id_next;
            status_reg  <= status_next;
            eid_reg     <= eid_next;
            ridx_reg    <= ridx_next;
            rep_reg     <= rep_next;
            sgl_reg     <= sgl_next;
            cns_reg     <= cns_next;
            rnd_reg     <= rnd_next;
            ov_reg      <= ov_next;
            ost_reg     <= ost_next;
            oeid_reg    <= oeid_next;
            oridx_reg   <= oridx_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wr_addr] <= ent_wr_data;
        ent_rd_reg <= ent_mem[ent_rd_addr];
    end

    // Play-order memory
    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wr_addr] <= ord_wr_data;
        ord_rd_reg <= ord_mem[ord_rd_addr];
    end

    // Id map memory
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wr_addr] <= map_wr_data;
        map_rd_reg <= map_mem[map_rd_addr];
    end

`ifndef SYNTHESIS
    // A free id found by append grows the list by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AP_CK && !map_rd_reg.used)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the list");

    // The list never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    // A response appears only from the completion state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_DONE))
        else $error("response loaded outside completion");
`endif

endmodule
